### src/cfq_pkg.sv
// ----------------------------------------------------------------------------
// cfq_pkg : shared types and constants of the circular FIFO queue
// Sizes of the ring store, command and status codes, controller states and
// the structs passed between the queue controller and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cfq_pkg;

    // Storage geometry
    localparam int DEPTH   = 1024;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int MIN_CAP = 5;

    // Channel payload sizes
    localparam int MODE_W     = 3;
    localparam int STAT_W     = 2;
    localparam int CFG_W      = 11;
    localparam int S_TDATA_W  = ((DATA_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = DATA_W + 2 + CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // Command codes
    localparam logic [MODE_W-1:0] MODE_ENQ       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEQ       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FRONT_DEQ = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // Controller states
    typedef enum logic {
        FSM_IDLE,
        FSM_READ
    } fsm_state_t;

    // Result of one command, as decided at acceptance
    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic [STAT_W-1:0] status;
        logic              is_empty;
        logic              is_full;
        logic [CNT_W-1:0]  count;
        logic              need_read;
    } result_t;

    // Ring store access request
    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
    } mem_req_t;

endpackage

`default_nettype wire

### src/cfq_ram.sv
// ----------------------------------------------------------------------------
// cfq_ram : generic single-port synchronous RAM
// One access per cycle, write or read; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or registered read
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

### src/cfq_ctrl.sv
// ----------------------------------------------------------------------------
// cfq_ctrl : ring pointers, fill count and capacity register
// Decodes one command per transfer, moves head and tail around the ring,
// issues the ring store access and works out status, flags and count.
// ----------------------------------------------------------------------------
`default_nettype none

module cfq_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [cfq_pkg::CFG_W-1:0]    cfg_wr_data,
    input  wire logic                         step,
    input  wire logic [cfq_pkg::MODE_W-1:0]   mode,
    output cfq_pkg::mem_req_t                 mem_req,
    output cfq_pkg::result_t                  res
);

    logic [cfq_pkg::CNT_W-1:0]  cap_reg,   cap_next;
    logic [cfq_pkg::ADDR_W-1:0] head_reg,  head_next;
    logic [cfq_pkg::ADDR_W-1:0] tail_reg,  tail_next;
    logic [cfq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [cfq_pkg::ADDR_W-1:0] head_adv,  tail_adv;
    logic                       empty, full;

    // Advance an index, wrapping at the capacity
    function automatic logic [cfq_pkg::ADDR_W-1:0] next_idx(
        input logic [cfq_pkg::ADDR_W-1:0] idx,
        input logic [cfq_pkg::CNT_W-1:0]  cap
    );
        logic [cfq_pkg::CNT_W-1:0] n;
        n = {1'b0, idx} + cfq_pkg::CNT_W'(1);
        return (n >= cap) ? '0 : n[cfq_pkg::ADDR_W-1:0];
    endfunction

    assign empty    = (count_reg == '0);
    assign full     = (count_reg >= cap_reg);
    assign head_adv = next_idx(head_reg, cap_reg);
    assign tail_adv = next_idx(tail_reg, cap_reg);

    // Clamped capacity from the config port
    always_comb begin
        cap_next = cfg_wr_data;
        if (cfg_wr_data < cfq_pkg::CNT_W'(cfq_pkg::MIN_CAP)) begin
            cap_next = cfq_pkg::CNT_W'(cfq_pkg::MIN_CAP);
        end else if (cfg_wr_data > cfq_pkg::CNT_W'(cfq_pkg::DEPTH)) begin
            cap_next = cfq_pkg::CNT_W'(cfq_pkg::DEPTH);
        end
    end

    // Command decode
    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        res.data_out  = '0;
        res.status    = cfq_pkg::STAT_OK;
        res.need_read = 1'b0;
        mem_req.en    = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.addr  = head_reg;
        case (mode)
            cfq_pkg::MODE_ENQ: begin
                if (full) begin
                    res.status = cfq_pkg::STAT_FULL;
                end else begin
                    count_next   = count_reg + cfq_pkg::CNT_W'(1);
                    tail_next    = tail_adv;
                    mem_req.en   = step;
                    mem_req.we   = 1'b1;
                    mem_req.addr = tail_adv;
                end
            end
            cfq_pkg::MODE_DEQ, cfq_pkg::MODE_PEEK, cfq_pkg::MODE_FRONT_DEQ: begin
                if (empty) begin
                    res.data_out = '1;
                    res.status   = cfq_pkg::STAT_EMPTY;
                end else begin
                    if (mode != cfq_pkg::MODE_DEQ) begin
                        res.need_read = 1'b1;
                        mem_req.en    = step;
                    end
                    if (mode != cfq_pkg::MODE_PEEK) begin
                        count_next = count_reg - cfq_pkg::CNT_W'(1);
                        head_next  = head_adv;
                    end
                end
            end
            cfq_pkg::MODE_CLEAR: begin
                head_next  = cfq_pkg::ADDR_W'(1);
                tail_next  = '0;
                count_next = '0;
            end
            default: begin
            end
        endcase
        res.count    = count_next;
        res.is_empty = (count_next == '0);
        res.is_full  = (count_next >= cap_reg);
    end

    // State registers; a capacity write starts a fresh queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= cfq_pkg::CNT_W'(cfq_pkg::DEPTH);
            head_reg  <= cfq_pkg::ADDR_W'(1);
            tail_reg  <= '0;
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            cap_reg   <= cap_next;
            head_reg  <= cfq_pkg::ADDR_W'(1);
            tail_reg  <= '0;
            count_reg <= '0;
        end else if (step) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Checks
    a_count_le_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cap_reg)
        else $error("fill count above capacity");

    a_cap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cap_reg >= cfq_pkg::CNT_W'(cfq_pkg::MIN_CAP) &&
        cap_reg <= cfq_pkg::CNT_W'(cfq_pkg::DEPTH))
        else $error("capacity out of range");

    a_head_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, head_reg} < cap_reg && {1'b0, tail_reg} < cap_reg)
        else $error("ring index beyond capacity");

endmodule

`default_nettype wire

### src/circular_fifo_queue.sv
// ----------------------------------------------------------------------------
// circular_fifo_queue : FIFO queue in a ring store with settable capacity
//
// Commands arrive on the s_ stream, one per transfer: s_tuser carries the
// command (enqueue, dequeue, peek, front-and-dequeue, clear), s_tdata the
// value to enqueue. Each command yields exactly one result transfer on the
// m_ stream: the front value for peek and front-and-dequeue (-1 for a dequeue,
// peek or front-and-dequeue on an empty queue, else 0), a status in m_tuser and
// the empty flag, full flag and count after the command in m_tdata.
// Enqueue, dequeue, clear and any command on an empty queue register their
// result directly at acceptance; peek and front-and-dequeue read the ring
// store (single-port RAM, registered read) and pass through the read state
// first. Throughput: one command per cycle while the result stream does not
// stall, except that a reading command holds the input in the read state while the RAM read completes.
// The result register stalls with m_tready low; while a result waits, no new
// command is taken, and one is taken in the same cycle the result drains.
// cfg_wr_en writes the capacity (clamped to 5..1024) and empties the queue.
// Reset empties the queue and sets the capacity to 1024; the ring store
// itself is not cleared, only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_fifo_queue (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Capacity register write
    input  wire logic                            cfg_wr_en,
    input  wire logic [cfq_pkg::CFG_W-1:0]       cfg_wr_data,
    // Command stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [cfq_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] data_in
    input  wire logic [cfq_pkg::MODE_W-1:0]      s_tuser,   // [2:0] mode
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [cfq_pkg::M_TDATA_W-1:0]   m_tdata,   // [31:0] data_out,
                                                            // [32] is_empty,
                                                            // [33] is_full,
                                                            // [44:34] count,
                                                            // [47:45] zero
    output logic      [cfq_pkg::STAT_W-1:0]      m_tuser    // [1:0] status
);

    cfq_pkg::fsm_state_t  state_reg, state_next;
    cfq_pkg::mem_req_t    mem_req;
    cfq_pkg::result_t     res;
    cfq_pkg::result_t     hold_reg;
    logic [cfq_pkg::DATA_W-1:0] rdata;
    logic                 s_accept;
    logic                 m_valid_reg;
    logic [cfq_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [cfq_pkg::STAT_W-1:0]    m_tuser_reg;

    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Pointer and count control
    cfq_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (s_accept),
        .mode        (s_tuser),
        .mem_req     (mem_req),
        .res         (res)
    );

    // Ring store
    cfq_ram #(
        .WIDTH (cfq_pkg::DATA_W),
        .DEPTH (cfq_pkg::DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (s_tdata[cfq_pkg::DATA_W-1:0]),
        .rdata (rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cfq_pkg::FSM_IDLE: begin
                if (s_accept && res.need_read) begin
                    state_next = cfq_pkg::FSM_READ;
                end
            end
            cfq_pkg::FSM_READ: begin
                state_next = cfq_pkg::FSM_IDLE;
            end
            default: begin
                state_next = cfq_pkg::FSM_IDLE;
            end
        endcase
    end

    // Input ready: idle and result slot free or draining
    always_comb begin
        s_tready = 1'b0;
        case (state_reg)
            cfq_pkg::FSM_IDLE: s_tready = !m_valid_reg || m_tready;
            default:           s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cfq_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Result fields kept while the RAM read is in flight
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            hold_reg <= res;
        end
    end

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == cfq_pkg::FSM_READ) begin
            m_valid_reg <= 1'b1;
        end else if (s_accept && !res.need_read) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (state_reg == cfq_pkg::FSM_READ) begin
            m_tdata_reg <= {{cfq_pkg::M_PAD_W{1'b0}}, hold_reg.count, hold_reg.is_full,
                            hold_reg.is_empty, rdata};
            m_tuser_reg <= hold_reg.status;
        end else if (s_accept && !res.need_read) begin
            m_tdata_reg <= {{cfq_pkg::M_PAD_W{1'b0}}, res.count, res.is_full,
                            res.is_empty, res.data_out};
            m_tuser_reg <= res.status;
        end
    end

    // Checks
    a_read_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == cfq_pkg::FSM_READ |-> !m_valid_reg)
        else $error("result slot busy during ring read");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> !(m_valid_reg && !m_tready))
        else $error("command taken over a stalled result");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_tdata_reg[cfq_pkg::DATA_W] ==
                         (m_tdata_reg[cfq_pkg::DATA_W+2 +: cfq_pkg::CNT_W] == '0)))
        else $error("empty flag disagrees with count");

endmodule

`default_nettype wire

### tb/tb_circular_fifo_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_fifo_queue : self-checking bench for the circular FIFO queue
// Drives queue commands on the s_ stream in bursts and keeps its own copy of
// the ring, the indices, the count and the capacity. From these it predicts
// every result, and each m_ transfer is checked field by field against the
// oldest prediction. Capacity writes happen only while the block is idle.
// The receiver stalls at random, with one long hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_circular_fifo_queue;

    // Modes with no operation
    localparam logic [cfq_pkg::MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [cfq_pkg::MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
    localparam logic [cfq_pkg::CFG_W-1:0]  CFG_ALL_ONES   = '1;
    localparam int                         CYCLE_LIMIT    = 400000;
    localparam int                         SETTLE_CYCLES  = 4;

    // One predicted result transfer
    typedef struct {
        logic [cfq_pkg::DATA_W-1:0] data_out;
        logic [cfq_pkg::STAT_W-1:0] status;
        logic                       is_empty;
        logic                       is_full;
        logic [cfq_pkg::CNT_W-1:0]  count;
    } queue_reply_t;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [cfq_pkg::CFG_W-1:0]     cfg_wr_data = '0;
    logic                          s_tvalid    = 1'b0;
    logic                          s_tready;
    logic [cfq_pkg::S_TDATA_W-1:0] s_tdata     = '0;
    logic [cfq_pkg::MODE_W-1:0]    s_tuser     = '0;
    logic                          m_tvalid;
    logic                          m_tready    = 1'b0;
    logic [cfq_pkg::M_TDATA_W-1:0] m_tdata;
    logic [cfq_pkg::STAT_W-1:0]    m_tuser;

    // Shadow of the queue
    logic [cfq_pkg::DATA_W-1:0] ring_shadow [cfq_pkg::DEPTH];
    int unsigned       shadow_cap   = cfq_pkg::DEPTH;
    int unsigned       shadow_head  = 1;
    int unsigned       shadow_tail  = 0;
    int unsigned       shadow_count = 0;

    queue_reply_t predicted_replies [$];
    queue_reply_t oldest_reply;

    int fail_count    = 0;
    int cmd_count     = 0;
    int checked_count = 0;
    int full_refusals = 0;
    int empty_replies = 0;
    int cycle_count   = 0;

    // Receiver controls
    int ready_pct = 100;
    int hold_req  = 0;
    int hold_left = 0;

    circular_fifo_queue DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),      // [31:0] data_in
        .s_tuser    (s_tuser),      // [2:0] mode
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),      // [31:0] data_out, [32] is_empty,
                                    // [33] is_full, [44:34] count
        .m_tuser    (m_tuser)       // [1:0] status
    );

    // Clock, 10 ns period
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) < ready_pct);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_replies.size() == 0) begin
                $error("result transfer with nothing expected: tdata %h tuser %h",
                       m_tdata, m_tuser);
                fail_count++;
            end else begin
                oldest_reply = predicted_replies.pop_front();
                checked_count++;
                if (m_tdata[31:0] !== oldest_reply.data_out) begin
                    $error("data_out: expected %h, got %h",
                           oldest_reply.data_out, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tuser !== oldest_reply.status) begin
                    $error("status: expected %0d, got %0d", oldest_reply.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[32] !== oldest_reply.is_empty) begin
                    $error("is_empty: expected %0b, got %0b",
                           oldest_reply.is_empty, m_tdata[32]);
                    fail_count++;
                end
                if (m_tdata[33] !== oldest_reply.is_full) begin
                    $error("is_full: expected %0b, got %0b",
                           oldest_reply.is_full, m_tdata[33]);
                    fail_count++;
                end
                if (m_tdata[44:34] !== oldest_reply.count) begin
                    $error("count: expected %0d, got %0d",
                           oldest_reply.count, m_tdata[44:34]);
                    fail_count++;
                end
            end
        end
    end

    function automatic int unsigned ring_next(input int unsigned idx);
        return (idx + 1 >= shadow_cap) ? 0 : idx + 1;
    endfunction

    // Apply one command to the shadow queue and record the reply it gives
    task automatic predict_queue_op(input logic [cfq_pkg::MODE_W-1:0] mode,
                                    input logic [cfq_pkg::DATA_W-1:0] din);
        queue_reply_t r;
        r.data_out = '0;
        r.status   = cfq_pkg::STAT_OK;
        case (mode)
            cfq_pkg::MODE_ENQ: begin
                if (shadow_count >= shadow_cap) begin
                    r.status = cfq_pkg::STAT_FULL;
                    full_refusals++;
                end else begin
                    shadow_count++;
                    shadow_tail = ring_next(shadow_tail);
                    ring_shadow[shadow_tail] = din;
                end
            end
            cfq_pkg::MODE_DEQ, cfq_pkg::MODE_PEEK, cfq_pkg::MODE_FRONT_DEQ: begin
                if (shadow_count == 0) begin
                    r.data_out = '1;
                    r.status   = cfq_pkg::STAT_EMPTY;
                    empty_replies++;
                end else begin
                    if (mode != cfq_pkg::MODE_DEQ)
                        r.data_out = ring_shadow[shadow_head];
                    if (mode != cfq_pkg::MODE_PEEK) begin
                        shadow_count--;
                        shadow_head = ring_next(shadow_head);
                    end
                end
            end
            cfq_pkg::MODE_CLEAR: begin
                shadow_head  = 1;
                shadow_tail  = 0;
                shadow_count = 0;
            end
            default: ;
        endcase
        r.is_empty = (shadow_count == 0);
        r.is_full  = (shadow_count >= shadow_cap);
        r.count    = shadow_count[cfq_pkg::CNT_W-1:0];
        predicted_replies.push_back(r);
        cmd_count++;
    endtask

    // Offer one command and wait for its transfer
    task automatic send_cmd(input logic [cfq_pkg::MODE_W-1:0] mode,
                            input logic [cfq_pkg::DATA_W-1:0] din);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= din;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_queue_op(mode, din);
    endtask

    task automatic sender_gap(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    // Pause the sender until every expected result has come
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (predicted_replies.size() != 0)
            @(posedge aclk);
    endtask

    // Capacity write, only with the block idle
    task automatic set_capacity(input logic [cfq_pkg::CFG_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        if (value < cfq_pkg::MIN_CAP)
            shadow_cap = cfq_pkg::MIN_CAP;
        else if (value > cfq_pkg::DEPTH)
            shadow_cap = cfq_pkg::DEPTH;
        else
            shadow_cap = 32'(value);
        shadow_head  = 1;
        shadow_tail  = 0;
        shadow_count = 0;
    endtask

    function automatic logic [cfq_pkg::MODE_W-1:0] pick_mode(input int enq_pct);
        int r;
        r = $urandom_range(99);
        if (r < enq_pct)
            return cfq_pkg::MODE_ENQ;
        r = $urandom_range(99);
        if (r < 30)
            return cfq_pkg::MODE_DEQ;
        if (r < 58)
            return cfq_pkg::MODE_PEEK;
        if (r < 92)
            return cfq_pkg::MODE_FRONT_DEQ;
        if (r < 96)
            return cfq_pkg::MODE_CLEAR;
        return cfq_pkg::MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
    endfunction

    // Bursts of commands with random gaps; the enqueue share changes per
    // burst so the queue swings between empty and full
    task automatic send_traffic(input int n_items, input int max_gap);
        int sent;
        int burst;
        int enq_pct;
        sent = 0;
        while (sent < n_items) begin
            burst   = $urandom_range(16, 1);
            enq_pct = $urandom_range(85, 20);
            repeat (burst) begin
                send_cmd(pick_mode(enq_pct), $urandom);
                sent++;
            end
            sender_gap($urandom_range(max_gap, 0));
        end
    endtask

    // Every command on an empty and a filled queue, data extremes
    task automatic test_basic_commands();
        ready_pct = 100;
        send_cmd(cfq_pkg::MODE_DEQ, 32'h0);
        send_cmd(cfq_pkg::MODE_PEEK, 32'h0);
        send_cmd(cfq_pkg::MODE_FRONT_DEQ, 32'h0);
        send_cmd(cfq_pkg::MODE_ENQ, 32'h7FFF_FFFF);
        send_cmd(cfq_pkg::MODE_ENQ, 32'h8000_0000);
        send_cmd(cfq_pkg::MODE_ENQ, 32'hFFFF_FFFF);
        send_cmd(cfq_pkg::MODE_ENQ, 32'h0000_0000);
        send_cmd(cfq_pkg::MODE_PEEK, 32'h0);
        send_cmd(cfq_pkg::MODE_FRONT_DEQ, 32'h0);
        send_cmd(cfq_pkg::MODE_DEQ, 32'h0);
        send_cmd(cfq_pkg::MODE_FRONT_DEQ, 32'h0);
        send_cmd(MODE_UNUSED_LO, $urandom);
        send_cmd(MODE_UNUSED_LO + 1'b1, $urandom);
        send_cmd(MODE_UNUSED_HI, $urandom);
        send_cmd(cfq_pkg::MODE_CLEAR, $urandom);
        send_cmd(cfq_pkg::MODE_PEEK, 32'h0);
        send_cmd(cfq_pkg::MODE_ENQ, 32'h1234_5678);
        send_cmd(cfq_pkg::MODE_FRONT_DEQ, 32'h0);
        wait_drained();
    endtask

    // Capacity clamping at both ends, full refusal, write clears the queue
    task automatic test_capacity_limits();
        set_capacity('0);
        repeat (6) send_cmd(cfq_pkg::MODE_ENQ, $urandom);
        send_cmd(cfq_pkg::MODE_PEEK, 32'h0);
        set_capacity(CFG_ALL_ONES);
        send_cmd(cfq_pkg::MODE_DEQ, 32'h0);
        set_capacity(cfq_pkg::CFG_W'(cfq_pkg::MIN_CAP - 1));
        repeat (7) send_cmd(cfq_pkg::MODE_ENQ, $urandom);
        repeat (3) send_cmd(cfq_pkg::MODE_FRONT_DEQ, 32'h0);
        set_capacity(cfq_pkg::CFG_W'(cfq_pkg::DEPTH + 1));
        send_cmd(cfq_pkg::MODE_ENQ, $urandom);
        send_cmd(cfq_pkg::MODE_PEEK, 32'h0);
        wait_drained();
    endtask

    // Random traffic over several capacities and receiver patterns
    task automatic test_random_traffic();
        set_capacity(cfq_pkg::CFG_W'(cfq_pkg::MIN_CAP));
        ready_pct = 70;
        send_traffic(50, 6);
        set_capacity(cfq_pkg::CFG_W'(cfq_pkg::MIN_CAP + 1));
        ready_pct = 100;
        send_traffic(30, 0);
        set_capacity(cfq_pkg::CFG_W'($urandom_range(40, 7)));
        ready_pct = 40;
        send_traffic(50, 4);
        set_capacity(cfq_pkg::CFG_W'($urandom));
        ready_pct = 85;
        send_traffic(40, 8);
        set_capacity(cfq_pkg::CFG_W'(cfq_pkg::DEPTH));
        ready_pct = 60;
        send_traffic(30, 3);
        wait_drained();
    endtask

    // Receiver holds off while commands keep coming; input must stall
    task automatic test_backpressure();
        set_capacity(cfq_pkg::CFG_W'(8));
        ready_pct = 100;
        @(posedge aclk);
        hold_req = 80;
        send_traffic(60, 0);
        wait_drained();
    endtask

    // Fill the largest ring to the brim, wrapping the tail, then clear it
    task automatic test_full_depth();
        set_capacity(CFG_ALL_ONES);
        ready_pct = 100;
        repeat (cfq_pkg::DEPTH + 1) send_cmd(cfq_pkg::MODE_ENQ, $urandom);
        send_cmd(cfq_pkg::MODE_PEEK, 32'h0);
        repeat (8) send_cmd(cfq_pkg::MODE_FRONT_DEQ, 32'h0);
        send_cmd(cfq_pkg::MODE_CLEAR, $urandom);
        repeat (10) send_cmd(pick_mode(60), $urandom);
        wait_drained();
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        test_basic_commands();
        test_capacity_limits();
        test_random_traffic();
        test_backpressure();
        test_full_depth();

        // Let any stray result show up before the verdict
        wait_drained();
        repeat (10) @(posedge aclk);
        while (predicted_replies.size() != 0) begin
            oldest_reply = predicted_replies.pop_front();
            $error("expected result never arrived: data_out %h status %0d",
                   oldest_reply.data_out, oldest_reply.status);
            fail_count++;
        end

        $display("Ran %0d commands over capacities 5 to %0d; %0d results checked",
                 cmd_count, cfq_pkg::DEPTH, checked_count);
        $display("Full refusals %0d, empty replies %0d, errors %0d",
                 full_refusals, empty_replies, fail_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
